// File: design/ritg_pkg.sv
// ----------------------------------------------------------------------------
// ritg_pkg: shared types and constants
// Field widths, parameter defaults and the structs that pass between the
// configuration, walk and result-stage modules.
// ----------------------------------------------------------------------------
package ritg_pkg;

  localparam int unsigned IdxW       = 16;  // vertex index width
  localparam int unsigned SideCfgW   = 5;   // side_count register width
  localparam int unsigned RingCfgW   = 7;   // ring_count register width
  localparam int unsigned CmpW       = 16;  // common width for counter compares
  localparam int unsigned PAddrW     = 3;
  localparam int unsigned PDataW     = 32;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 48;

  localparam int unsigned DefMaxSides = 16;
  localparam int unsigned DefMaxRings = 64;

  localparam logic [SideCfgW-1:0] SideReset = SideCfgW'(6);
  localparam logic [RingCfgW-1:0] RingReset = RingCfgW'(4);

  // register indexes, taken from paddr[2]
  localparam logic RegSideCount = 1'b0;
  localparam logic RegRingCount = 1'b1;

  typedef struct packed {
    logic [SideCfgW-1:0] side_count;
    logic [RingCfgW-1:0] ring_count;
    logic                restart;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0] corner_a;
    logic [IdxW-1:0] corner_b;
    logic [IdxW-1:0] corner_c;
    logic            mesh_last;
  } tri_t;

endpackage

// File: design/ritg_cfg.sv
// ----------------------------------------------------------------------------
// ritg_cfg: configuration registers
// APB-style write/read of side_count and ring_count, saturated into range;
// any write restarts the mesh walk.
// ----------------------------------------------------------------------------
module ritg_cfg #(
  parameter int unsigned MAX_SIDES = ritg_pkg::DefMaxSides,
  parameter int unsigned MAX_RINGS = ritg_pkg::DefMaxRings
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ritg_pkg::PAddrW-1:0]   paddr,
  input  logic [ritg_pkg::PDataW-1:0]   pwdata,
  output logic [ritg_pkg::PDataW-1:0]   prdata,
  output logic                          pready,
  output ritg_pkg::cfg_t                cfg_o
);

  localparam int unsigned CmpW = ritg_pkg::CmpW;

  logic [ritg_pkg::SideCfgW-1:0] side_q, side_d;
  logic [ritg_pkg::RingCfgW-1:0] ring_q, ring_d;
  logic                          wr_en;
  logic [ritg_pkg::SideCfgW-1:0] side_raw;
  logic [ritg_pkg::RingCfgW-1:0] ring_raw;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign side_raw = pwdata[ritg_pkg::SideCfgW-1:0];
  assign ring_raw = pwdata[ritg_pkg::RingCfgW-1:0];

  always_comb begin
    side_d = side_q;
    ring_d = ring_q;
    if (wr_en) begin
      case (paddr[2])
        ritg_pkg::RegSideCount: begin
          // clamp into 3..MAX_SIDES
          if (CmpW'(side_raw) < CmpW'(3)) begin
            side_d = ritg_pkg::SideCfgW'(3);
          end else if (CmpW'(side_raw) > CmpW'(MAX_SIDES)) begin
            side_d = ritg_pkg::SideCfgW'(MAX_SIDES);
          end else begin
            side_d = side_raw;
          end
        end
        ritg_pkg::RegRingCount: begin
          if (ring_raw == '0) begin
            ring_d = ritg_pkg::RingCfgW'(1);
          end else if (CmpW'(ring_raw) > CmpW'(MAX_RINGS)) begin
            ring_d = ritg_pkg::RingCfgW'(MAX_RINGS);
          end else begin
            ring_d = ring_raw;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= ritg_pkg::SideReset;
      ring_q <= ritg_pkg::RingReset;
    end else begin
      side_q <= side_d;
      ring_q <= ring_d;
    end
  end

  always_comb begin
    case (paddr[2])
      ritg_pkg::RegSideCount: prdata = ritg_pkg::PDataW'(side_q);
      ritg_pkg::RegRingCount: prdata = ritg_pkg::PDataW'(ring_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.side_count = side_q;
  assign cfg_o.ring_count = ring_q;
  assign cfg_o.restart    = wr_en;

endmodule

// File: design/ritg_walk.sv
// ----------------------------------------------------------------------------
// ritg_walk: ring walk state and triangle forming
// Holds layer, side and step counters plus ring cursors; forms one triangle
// per step and advances the walk in the same cycle.
// ----------------------------------------------------------------------------
module ritg_walk #(
  parameter int unsigned MAX_SIDES = ritg_pkg::DefMaxSides,
  parameter int unsigned MAX_RINGS = ritg_pkg::DefMaxRings
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ritg_pkg::cfg_t cfg_i,
  input  logic           step_i,
  output ritg_pkg::tri_t tri_o
);

  localparam int unsigned IdxW  = ritg_pkg::IdxW;
  localparam int unsigned CmpW  = ritg_pkg::CmpW;
  localparam int unsigned SideW = (MAX_SIDES > 1) ? $clog2(MAX_SIDES) : 1;
  localparam int unsigned LayW  = $clog2(MAX_RINGS + 1);
  localparam int unsigned StepW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;

  logic [LayW-1:0]  layer_q, layer_d;
  logic [SideW-1:0] side_q, side_d;
  logic [StepW-1:0] step_q, step_d;
  logic             inward_q, inward_d;
  logic [IdxW-1:0]  inner_q, inner_d;
  logic [IdxW-1:0]  outer_q, outer_d;
  logic [IdxW-1:0]  inner_base_q, inner_base_d;
  logic [IdxW-1:0]  outer_base_q, outer_base_d;

  logic            side_last;
  logic            step_last;
  logic            wrap;
  logic            mesh_end;
  logic [IdxW-1:0] outer_inc;
  logic [IdxW-1:0] inner_inc;
  logic [IdxW-1:0] corner_c;

  assign side_last = (CmpW'(side_q) + CmpW'(1)) == CmpW'(cfg_i.side_count);
  assign step_last = (CmpW'(step_q) + CmpW'(1)) == CmpW'(layer_q);
  assign wrap      = side_last && step_last;
  assign mesh_end  = CmpW'(layer_q) >= CmpW'(cfg_i.ring_count);
  assign outer_inc = outer_q + IdxW'(1);
  assign inner_inc = inner_q + IdxW'(1);

  always_comb begin
    if (inward_q) begin
      corner_c = wrap ? inner_base_q : inner_inc;
    end else begin
      corner_c = wrap ? outer_base_q : outer_inc;
    end
  end

  assign tri_o.corner_a  = inner_q;
  assign tri_o.corner_b  = outer_q;
  assign tri_o.corner_c  = corner_c;
  assign tri_o.mesh_last = !inward_q && step_last && side_last && mesh_end;

  always_comb begin
    layer_d      = layer_q;
    side_d       = side_q;
    step_d       = step_q;
    inward_d     = inward_q;
    inner_d      = inner_q;
    outer_d      = outer_q;
    inner_base_d = inner_base_q;
    outer_base_d = outer_base_q;
    if (cfg_i.restart || (step_i && tri_o.mesh_last)) begin
      layer_d      = LayW'(1);
      side_d       = '0;
      step_d       = '0;
      inward_d     = 1'b0;
      inner_d      = '0;
      outer_d      = IdxW'(1);
      inner_base_d = '0;
      outer_base_d = IdxW'(1);
    end else if (step_i) begin
      if (inward_q) begin
        inner_d  = corner_c;
        inward_d = 1'b0;
      end else begin
        outer_d = outer_inc;
        if (step_last) begin
          step_d   = '0;
          inward_d = 1'b0;
          if (side_last) begin
            // move out one ring
            layer_d      = layer_q + LayW'(1);
            side_d       = '0;
            inner_base_d = outer_base_q;
            inner_d      = outer_base_q;
            outer_base_d = outer_inc;
          end else begin
            side_d = side_q + SideW'(1);
          end
        end else begin
          step_d   = step_q + StepW'(1);
          inward_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q      <= LayW'(1);
      side_q       <= '0;
      step_q       <= '0;
      inward_q     <= 1'b0;
      inner_q      <= '0;
      outer_q      <= IdxW'(1);
      inner_base_q <= '0;
      outer_base_q <= IdxW'(1);
    end else begin
      layer_q      <= layer_d;
      side_q       <= side_d;
      step_q       <= step_d;
      inward_q     <= inward_d;
      inner_q      <= inner_d;
      outer_q      <= outer_d;
      inner_base_q <= inner_base_d;
      outer_base_q <= outer_base_d;
    end
  end

endmodule

// File: design/ritg_out_reg.sv
// ----------------------------------------------------------------------------
// ritg_out_reg: result register
// Holds one triangle for the master-side stream until it is taken.
// ----------------------------------------------------------------------------
module ritg_out_reg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  ritg_pkg::tri_t                  tri_i,
  output logic                            free_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ritg_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);

  logic           valid_q, valid_d;
  ritg_pkg::tri_t tri_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tri_q <= tri_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {tri_q.corner_c, tri_q.corner_b, tri_q.corner_a};
  assign m_axis_tlast  = tri_q.mesh_last;

endmodule

// File: design/ring_layer_triangle_index_generator.sv
// ----------------------------------------------------------------------------
// ring_layer_triangle_index_generator: triangle index stream for ring meshes
// Walks the rings of an n-sided polygon mesh and emits one vertex-index
// triple per advance request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: each request carries advance in tdata[0]. A request with
//   advance high yields one triangle; with advance low it is consumed and
//   dropped without a result and without moving the walk.
//   Master stream: tdata = {corner_c, corner_b, corner_a}, tlast marks the
//   final triangle of the mesh; the walk then starts over from triangle 0.
//   APB port: side_count at 0x0, ring_count at 0x4, values clamped into
//   range on write. Any write restarts the walk; write only while idle.
// Timing:
//   A request is registered in the input register when it is taken; its
//   triangle is formed from the walk state and registered in the result
//   register, which drives tvalid. While the receiver keeps tready high,
//   one triangle per cycle is sustained; the walk counters and ring cursors
//   update with each step. When the receiver stalls, the result register
//   holds and the input register fills; tready then drops until the result is taken.
// Reset:
//   Both streams empty, side_count 6, ring_count 4, walk at the first triangle.
// ----------------------------------------------------------------------------
module ring_layer_triangle_index_generator #(
  parameter int unsigned MAX_SIDES = ritg_pkg::DefMaxSides,
  parameter int unsigned MAX_RINGS = ritg_pkg::DefMaxRings
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ritg_pkg::PAddrW-1:0]   paddr,
  input  logic [ritg_pkg::PDataW-1:0]   pwdata,
  output logic [ritg_pkg::PDataW-1:0]   prdata,
  output logic                          pready,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ritg_pkg::InDataW-1:0]  s_axis_tdata,   // [0] advance, [7:1] zero
  // triangle stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ritg_pkg::OutDataW-1:0] m_axis_tdata,   // [15:0] corner_a,
                                                        // [31:16] corner_b,
                                                        // [47:32] corner_c
  output logic                          m_axis_tlast    // mesh_last
);

  ritg_pkg::cfg_t cfg;
  ritg_pkg::tri_t tri_w;

  logic in_valid_q, in_valid_d;
  logic in_adv_q;
  logic out_free;
  logic fire;
  logic step;
  logic take;

  // retire the held request when its result has room, or at once if it
  // asks for nothing
  assign fire          = in_valid_q && (!in_adv_q || out_free);
  assign step          = fire && in_adv_q;
  assign s_axis_tready = !in_valid_q || fire;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_adv_q <= s_axis_tdata[0];
    end
  end

  ritg_cfg #(
    .MAX_SIDES (MAX_SIDES),
    .MAX_RINGS (MAX_RINGS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ritg_walk #(
    .MAX_SIDES (MAX_SIDES),
    .MAX_RINGS (MAX_RINGS)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .tri_o  (tri_w)
  );

  ritg_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .tri_i         (tri_w),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: tb/ring_layer_triangle_index_generator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_layer_triangle_index_generator_checker: triangle stream scoreboard
// Follows APB writes and accepted requests and keeps its own copy of the
// ring walk. Each request with advance set queues the triangle that the walk
// must produce. Each triangle taken from the master stream is compared
// field by field with the oldest queued one. APB reads are checked against
// the clamped register values.
// ----------------------------------------------------------------------------
module ring_layer_triangle_index_generator_checker
  import ritg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PAddrW-1:0]   paddr,
  input  logic [PDataW-1:0]   pwdata,
  input  logic [PDataW-1:0]   prdata,
  input  logic                pready,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] advance, [7:1] zero
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // [15:0] corner_a, [31:16] corner_b,
                                              // [47:32] corner_c
  input  logic                m_axis_tlast,   // mesh_last
  output int unsigned         fail_count_o,
  output int unsigned         triangles_due_o
);

  int unsigned     sides;
  int unsigned     rings;
  int unsigned     layer;
  int unsigned     side;
  int unsigned     pos_in_side;
  bit              inward;
  logic [IdxW-1:0] inner_cur;
  logic [IdxW-1:0] outer_cur;
  logic [IdxW-1:0] inner_base;
  logic [IdxW-1:0] outer_base;
  tri_t            triangles_due[$];

  function automatic void restart_walk();
    layer       = 1;
    side        = 0;
    pos_in_side = 0;
    inward      = 1'b0;
    inner_cur   = '0;
    outer_cur   = IdxW'(1);
    inner_base  = '0;
    outer_base  = IdxW'(1);
  endfunction

  // Emit the triangle at the current walk position and advance the walk.
  function automatic tri_t next_triangle();
    tri_t t;
    bit   wrap;
    wrap        = (side == sides - 1) && (pos_in_side == layer - 1);
    t.corner_a  = inner_cur;
    t.corner_b  = outer_cur;
    t.mesh_last = 1'b0;
    if (!inward) begin
      t.corner_c  = wrap ? outer_base : outer_cur + IdxW'(1);
      outer_cur   = outer_cur + IdxW'(1);
      pos_in_side = pos_in_side + 1;
      if (pos_in_side == layer) begin
        pos_in_side = 0;
        if (side == sides - 1) begin
          if (layer >= rings) begin
            t.mesh_last = 1'b1;
            restart_walk();
          end else begin
            layer      = layer + 1;
            side       = 0;
            inner_base = outer_base;
            inner_cur  = outer_base;
            outer_base = outer_cur;
          end
        end else begin
          side = side + 1;
        end
      end else begin
        inward = 1'b1;
      end
    end else begin
      t.corner_c = wrap ? inner_base : inner_cur + IdxW'(1);
      inner_cur  = t.corner_c;
      inward     = 1'b0;
    end
    return t;
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tri_t want;
    if (!rst_ni) begin
      sides        = SideReset;
      rings        = RingReset;
      fail_count_o = 0;
      restart_walk();
      triangles_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          // any write clamps the value and restarts the walk
          if (paddr[2] == RegSideCount) begin
            sides = clamp(pwdata & 'h1F, 3, DefMaxSides);
          end else begin
            rings = clamp(pwdata & 'h7F, 1, DefMaxRings);
          end
          restart_walk();
        end else if (paddr[2] == RegSideCount) begin
          if (prdata != sides) report_mismatch("side_count readback", prdata, sides);
        end else begin
          if (prdata != rings) report_mismatch("ring_count readback", prdata, rings);
        end
      end

      if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) begin
        triangles_due.insert(triangles_due.size(), next_triangle());
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (triangles_due.size() == 0) begin
          report_mismatch("unexpected triangle, corner_a", m_axis_tdata[15:0], 0);
        end else begin
          want = triangles_due.pop_front();
          if (m_axis_tdata[15:0] != want.corner_a)
            report_mismatch("corner_a", m_axis_tdata[15:0], want.corner_a);
          if (m_axis_tdata[31:16] != want.corner_b)
            report_mismatch("corner_b", m_axis_tdata[31:16], want.corner_b);
          if (m_axis_tdata[47:32] != want.corner_c)
            report_mismatch("corner_c", m_axis_tdata[47:32], want.corner_c);
          if (m_axis_tlast != want.mesh_last)
            report_mismatch("mesh_last", m_axis_tlast, want.mesh_last);
        end
      end
    end
    triangles_due_o = triangles_due.size();
  end

endmodule

// File: tb/ring_layer_triangle_index_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_layer_triangle_index_generator_tb: top-level testbench
// Drives the APB port and the request stream of the triangle index generator
// and stalls the triangle stream; the checker beside the block predicts and
// compares. A directed part covers the smallest meshes, advance low, clamped
// register values and the largest setting, then random phases vary the mesh
// size and the idling on both streams.
// ----------------------------------------------------------------------------
module ring_layer_triangle_index_generator_tb;
  import ritg_pkg::*;

  localparam logic        ApbWrite  = 1'b1;
  localparam logic        ApbRead   = 1'b0;
  localparam int unsigned CycleLimit = 400_000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PAddrW-1:0]   paddr         = '0;
  logic [PDataW-1:0]   pwdata        = '0;
  logic [PDataW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int unsigned fail_count;
  int unsigned triangles_due;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;

  ring_layer_triangle_index_generator i_dut (.*);

  ring_layer_triangle_index_generator_checker i_checker (
    .fail_count_o    (fail_count),
    .triangles_due_o (triangles_due),
    .*
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic idx, input logic [PDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Keep tvalid high across back-to-back requests; lower it only for a gap.
  task automatic push_request(input logic advance);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-1){1'b0}}, advance};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drain: wait for every triangle, then cover requests that give none.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (triangles_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [PDataW-1:0] value;
    int unsigned       n;
    int unsigned       sent;
    logic              advance;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(ApbRead, RegSideCount, '0);
    apb_access(ApbRead, RegRingCount, '0);

    // smallest mesh: three triangles, mesh_last, then the walk starts over
    apb_access(ApbWrite, RegSideCount, 3);
    apb_access(ApbWrite, RegRingCount, 1);
    push_request(1'b1);
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b1);
    settle();

    // two rings: twelve requests, one with advance low, give eleven triangles with inward ones and the ring wrap
    apb_access(ApbWrite, RegRingCount, 2);
    for (int i = 0; i < 12; i++) push_request(i != 5);
    settle();

    // out-of-range values clamp into range
    apb_access(ApbWrite, RegSideCount, 0);
    apb_access(ApbRead,  RegSideCount, '0);
    apb_access(ApbWrite, RegSideCount, 2);
    apb_access(ApbRead,  RegSideCount, '0);
    apb_access(ApbWrite, RegSideCount, 31);
    apb_access(ApbRead,  RegSideCount, '0);
    apb_access(ApbWrite, RegSideCount, 17);
    apb_access(ApbRead,  RegSideCount, '0);
    apb_access(ApbWrite, RegSideCount, 32'hFFFF_FFF0);
    apb_access(ApbRead,  RegSideCount, '0);
    apb_access(ApbWrite, RegRingCount, 0);
    apb_access(ApbRead,  RegRingCount, '0);
    apb_access(ApbWrite, RegRingCount, 127);
    apb_access(ApbRead,  RegRingCount, '0);
    apb_access(ApbWrite, RegRingCount, 65);
    apb_access(ApbRead,  RegRingCount, '0);
    apb_access(ApbWrite, RegRingCount, 32'hABCD_EF80);
    apb_access(ApbRead,  RegRingCount, '0);

    // largest setting
    apb_access(ApbWrite, RegRingCount, 64);
    apb_access(ApbWrite, RegSideCount, 16);
    for (int i = 0; i < 6; i++) push_request(1'b1);
    settle();

    for (int phase = 0; phase < 20; phase++) begin
      if ($urandom_range(1) == 1) begin
        value = ($urandom_range(4) == 0) ? $urandom : $urandom_range(16, 3);
        apb_access(ApbWrite, RegSideCount, value);
      end
      case ($urandom_range(9))
        0:       value = $urandom;
        1:       value = $urandom_range(64, 1);
        default: value = $urandom_range(5, 1);
      endcase
      apb_access(ApbWrite, RegRingCount, value);
      apb_access(ApbRead, RegSideCount, '0);
      apb_access(ApbRead, RegRingCount, '0);

      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 56; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase

      n    = $urandom_range(100, 36);
      sent = 0;
      while (sent < n) begin
        advance = ($urandom_range(99) >= 15);
        push_request(advance);
        if (advance) sent++;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
